@@ src/assert_macros.svh @@
// Assertion macros shared by the colorizer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed");

// A condition that must hold a fixed number of cycles after its trigger.
`define ASSERT_DELAYED(lbl, trig, n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> ##n (cond)) \
		else $error("delayed assertion failed");

`endif

@@ src/ehc_pkg.sv @@
// Package of the elevation colorizer: payload, configuration and sideband types.
// Has no dependencies; every RTL module of the block imports it.
package ehc_pkg;

	localparam int ELEV_W     = 24;
	localparam int HUE_W      = 13;
	localparam int SAT_W      = 17;
	localparam int HUE_FULL   = 5760;
	localparam int HUE_SECTOR = 960;
	localparam int CFG_W      = 24;

	typedef enum logic [2:0] {
		REG_HUE_START   = 3'd0,
		REG_HUE_RANGE   = 3'd1,
		REG_SATURATION  = 3'd2,
		REG_BRIGHTNESS  = 3'd3,
		REG_MODE_FLAGS  = 3'd4,
		REG_WATER_LEVEL = 3'd5,
		REG_WATER_ALPHA = 3'd6,
		REG_WATER_RGB   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [ELEV_W-1:0] elevation;
		logic signed [ELEV_W-1:0] min_elevation;
		logic signed [ELEV_W-1:0] max_elevation;
		logic [7:0]               light_intensity;
		logic                     keep_color;
		logic [7:0]               in_red;
		logic [7:0]               in_green;
		logic [7:0]               in_blue;
	} item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} result_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_start;
		logic [HUE_W-1:0]  hue_range;
		logic [SAT_W-1:0]  saturation;
		logic [SAT_W-1:0]  brightness;
		logic [1:0]        mode_flags;
		logic signed [23:0] water_level;
		logic [7:0]        water_alpha;
		logic [23:0]       water_rgb;
	} cfg_t;

	// Per-pixel data that rides along the pipeline untouched.
	typedef struct packed {
		logic       keep;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] inten;
		logic       wet;
	} side_t;

	// Exact floor(x / 255) for any x below 65280.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

@@ src/ehc_hue_map.sv @@
// Elevation to hue sector and offset: span clamp, scale, restoring divider, wrap.
// Depends on ehc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ehc_hue_map import ehc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  item_t      item,
	input  cfg_t       cfg,
	output logic       out_valid,
	output logic [2:0] sector,
	output logic [9:0] frac,
	output side_t      side
);
	localparam int DW = ELEV_W;
	localparam int PW = HUE_W + DW;
	localparam int QB = HUE_W;

	logic signed [DW:0] dz_c, num_c;
	logic [DW-1:0]      dzk_c, numk_c;
	logic signed [32:0] ev33, wl33;
	side_t              side_c;

	always_comb begin
		dz_c  = $signed({item.max_elevation[DW-1], item.max_elevation})
		      - $signed({item.min_elevation[DW-1], item.min_elevation});
		num_c = $signed({item.elevation[DW-1], item.elevation})
		      - $signed({item.min_elevation[DW-1], item.min_elevation});
		if (dz_c <= 0) begin
			dz_c = (DW+1)'(1);
		end
		if (num_c < 0) begin
			num_c = '0;
		end else if (num_c > dz_c) begin
			num_c = dz_c;
		end
		dzk_c  = dz_c[DW-1:0];
		numk_c = num_c[DW-1:0];
		ev33   = 33'(item.elevation);
		wl33   = 33'(cfg.water_level);
		side_c.keep  = item.keep_color;
		side_c.red   = item.in_red;
		side_c.green = item.in_green;
		side_c.blue  = item.in_blue;
		side_c.inten = item.light_intensity;
		side_c.wet   = (ev33 <= wl33);
	end

	logic          v_s1;
	logic [DW-1:0] dz_s1, num_s1;
	side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dz_s1   <= dzk_c;
		num_s1  <= numk_c;
		side_s1 <= side_c;
	end

	// Divider stage arrays; index 0 holds the scaled numerator.
	logic          v_s   [0:QB];
	logic [PW-1:0] rem_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [DW-1:0] dz_s  [0:QB];
	side_t         sd_s  [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= PW'(cfg.hue_range) * PW'(num_s1);
		quo_s[0] <= '0;
		dz_s[0]  <= dz_s1;
		sd_s[0]  <= side_s1;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [PW-1:0] trial;
		assign trial = PW'(dz_s[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial;
				quo_s[k+1] <= quo_s[k] | (QB'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				quo_s[k+1] <= quo_s[k];
			end
			dz_s[k+1] <= dz_s[k];
			sd_s[k+1] <= sd_s[k];
		end
	end

	// Wrap the hue into one turn; the sum stays below three turns.
	logic [HUE_W:0]   hsum_c;
	logic [HUE_W-1:0] hwrap_c;

	always_comb begin
		hsum_c = (HUE_W+1)'(quo_s[QB]) + (HUE_W+1)'(cfg.hue_start);
		if (hsum_c >= (HUE_W+1)'(2 * HUE_FULL)) begin
			hwrap_c = HUE_W'(hsum_c - (HUE_W+1)'(2 * HUE_FULL));
		end else if (hsum_c >= (HUE_W+1)'(HUE_FULL)) begin
			hwrap_c = HUE_W'(hsum_c - (HUE_W+1)'(HUE_FULL));
		end else begin
			hwrap_c = HUE_W'(hsum_c);
		end
	end

	logic             v_s16;
	logic [HUE_W-1:0] hue_s16;
	side_t            side_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else begin
			v_s16 <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		hue_s16  <= hwrap_c;
		side_s16 <= sd_s[QB];
	end

	logic [2:0] sec_c;
	logic [9:0] frac_c;

	always_comb begin
		if (hue_s16 >= HUE_W'(5 * HUE_SECTOR)) begin
			sec_c  = 3'd5;
			frac_c = 10'(hue_s16 - HUE_W'(5 * HUE_SECTOR));
		end else if (hue_s16 >= HUE_W'(4 * HUE_SECTOR)) begin
			sec_c  = 3'd4;
			frac_c = 10'(hue_s16 - HUE_W'(4 * HUE_SECTOR));
		end else if (hue_s16 >= HUE_W'(3 * HUE_SECTOR)) begin
			sec_c  = 3'd3;
			frac_c = 10'(hue_s16 - HUE_W'(3 * HUE_SECTOR));
		end else if (hue_s16 >= HUE_W'(2 * HUE_SECTOR)) begin
			sec_c  = 3'd2;
			frac_c = 10'(hue_s16 - HUE_W'(2 * HUE_SECTOR));
		end else if (hue_s16 >= HUE_W'(HUE_SECTOR)) begin
			sec_c  = 3'd1;
			frac_c = 10'(hue_s16 - HUE_W'(HUE_SECTOR));
		end else begin
			sec_c  = 3'd0;
			frac_c = 10'(hue_s16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		sector <= sec_c;
		frac   <= frac_c;
		side   <= side_s16;
	end

	`ASSERT_IMPLIES(a_sector_range, out_valid, (sector <= 3'd5) && (frac < 10'(HUE_SECTOR)))

endmodule

@@ src/ehc_hsv_rgb.sv @@
// HSV to 8-bit RGB: sector terms, value product, scaling by 255/960 and clamp, or the kept color.
// Depends on ehc_pkg.
module ehc_hsv_rgb import ehc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2:0]      sector,
	input  logic [9:0]      frac,
	input  side_t           side_in,
	input  cfg_t            cfg,
	output logic            out_valid,
	output logic [2:0][7:0] ch,
	output side_t           side
);
	localparam logic signed [28:0] X_FULL = 29'sd62914560;

	logic signed [18:0] oms_c;
	logic [26:0]        sf_c, sfc_c;

	always_comb begin
		oms_c = 19'sd65536 - $signed({2'b00, cfg.saturation});
		sf_c  = 27'(cfg.saturation) * 27'(frac);
		sfc_c = 27'(cfg.saturation) * 27'(10'(HUE_SECTOR) - frac);
	end

	logic               v_s18;
	logic signed [28:0] x1_s18, x2_s18, x3_s18;
	logic [2:0]         sec_s18;
	side_t              side_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s18 <= 1'b0;
		end else begin
			v_s18 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x1_s18   <= 29'(oms_c) * 29'sd960;
		x2_s18   <= X_FULL - $signed({2'b00, sf_c});
		x3_s18   <= X_FULL - $signed({2'b00, sfc_c});
		sec_s18  <= sector;
		side_s18 <= side_in;
	end

	logic signed [2:0][28:0] xsel_c;
	logic [2:0][27:0]        xpos_c;

	always_comb begin
		case (sec_s18)
			3'd0: begin
				xsel_c = {X_FULL, x3_s18, x1_s18};
			end
			3'd1: begin
				xsel_c = {x2_s18, X_FULL, x1_s18};
			end
			3'd2: begin
				xsel_c = {x1_s18, X_FULL, x3_s18};
			end
			3'd3: begin
				xsel_c = {x1_s18, x2_s18, X_FULL};
			end
			3'd4: begin
				xsel_c = {x3_s18, x1_s18, X_FULL};
			end
			default: begin
				xsel_c = {X_FULL, x1_s18, x2_s18};
			end
		endcase
		// An element select of a packed array is unsigned, so the sign test
		// needs the explicit signed view.
		for (int i = 0; i < 3; i++) begin
			xpos_c[i] = ($signed(xsel_c[i]) <= 0) ? '0 : xsel_c[i][27:0];
		end
	end

	logic             v_s19;
	logic [2:0][44:0] prod_s19;
	side_t            side_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s19 <= 1'b0;
		end else begin
			v_s19 <= v_s18;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s19[i] <= 45'(cfg.brightness) * 45'(xpos_c[i]);
		end
		side_s19 <= side_s18;
	end

	logic [2:0][52:0] y_c;
	logic [2:0][14:0] t_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			y_c[i] = {prod_s19[i], 8'b0} - 53'(prod_s19[i]);
			t_c[i] = y_c[i][52:38];
		end
	end

	logic             v_s20;
	logic [2:0][11:0] t_s20;
	logic [2:0]       sat_s20;
	side_t            side_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s20 <= 1'b0;
		end else begin
			v_s20 <= v_s19;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s20[i]   <= t_c[i][11:0];
			sat_s20[i] <= (t_c[i] >= 15'd3840);
		end
		side_s20 <= side_s19;
	end

	// Divide by 15 through a reciprocal; exact for the clamped range.
	logic [2:0][27:0] rq_c;
	logic [2:0][7:0]  ch_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rq_c[i] = 28'(t_s20[i]) * 28'd34953;
			ch_c[i] = sat_s20[i] ? 8'd255 : rq_c[i][26:19];
		end
		if (side_s20.keep) begin
			ch_c = {side_s20.red, side_s20.green, side_s20.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s20;
		end
	end

	always_ff @(posedge clk) begin
		ch   <= ch_c;
		side <= side_s20;
	end

endmodule

@@ src/ehc_shade.sv @@
// Lighting and water blend of the three color channels, with the output register.
// Depends on ehc_pkg.
module ehc_shade import ehc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2:0][7:0] ch,
	input  side_t           side_in,
	input  cfg_t            cfg,
	output logic            out_valid,
	output result_t         result
);
	logic [2:0][7:0] lit_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lit_c[i] = cfg.mode_flags[0] ? div255(16'(side_in.inten) * 16'(ch[i])) : ch[i];
		end
	end

	logic            v_s22;
	logic [2:0][7:0] lit_s22;
	logic            wet_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else begin
			v_s22 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lit_s22 <= lit_c;
		wet_s22 <= side_in.wet;
	end

	logic [2:0][7:0] wat_c, mix_c;
	logic [2:0][7:0] dlt_c;
	logic [2:0][7:0] stp_c;
	logic            blend_c;

	always_comb begin
		wat_c   = {cfg.water_rgb[23:16], cfg.water_rgb[15:8], cfg.water_rgb[7:0]};
		blend_c = cfg.mode_flags[1] && wet_s22 && (cfg.water_alpha != 8'd0);
		for (int i = 0; i < 3; i++) begin
			dlt_c[i] = (wat_c[i] >= lit_s22[i]) ? (wat_c[i] - lit_s22[i])
			                                    : (lit_s22[i] - wat_c[i]);
			stp_c[i] = div255(16'(dlt_c[i]) * 16'(cfg.water_alpha));
			if (!blend_c) begin
				mix_c[i] = lit_s22[i];
			end else if (wat_c[i] >= lit_s22[i]) begin
				mix_c[i] = lit_s22[i] + stp_c[i];
			end else begin
				mix_c[i] = lit_s22[i] - stp_c[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		result.out_red   <= mix_c[2];
		result.out_green <= mix_c[1];
		result.out_blue  <= mix_c[0];
	end

endmodule

@@ src/elevation_hsv_colorize_unit.sv @@
// Top level of the elevation colorizer: configuration registers and the pipeline.
// Depends on ehc_pkg, ehc_hue_map, ehc_hsv_rgb, ehc_shade and assert_macros.svh.
//
//   channel   handshake              payload     direction
//   pixel     start (busy is low)    in_item     in
//   color     done strobe            result      out
//   config    wr_en                  wr_index    in, with wr_data
//
// One pixel transaction is taken in every cycle; busy is always low.
// The result passes the registers of the hue map, HSV to RGB and shade stages
// and is held on the result ports for exactly one cycle with done high.
// The depth is set by the restoring divider, one quotient bit per stage for
// the 13-bit hue.
// Reset clears the configuration to its defaults and all pipeline valid bits.
// The receiver cannot stall, so the pipeline always advances.
`include "assert_macros.svh"
module elevation_hsv_colorize_unit import ehc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            in_item,
	output logic             done,
	output result_t          result,
	input  logic             wr_en,
	input  reg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data
);
	localparam int PIPE_LAT = 23;

	cfg_t cfg_q;

	// The user must see that configuration is written only while the pipeline is
	// empty, so the stages read the live registers; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_start   <= '0;
			cfg_q.hue_range   <= HUE_W'(HUE_FULL);
			cfg_q.saturation  <= SAT_W'(65536);
			cfg_q.brightness  <= SAT_W'(65536);
			cfg_q.mode_flags  <= 2'd3;
			cfg_q.water_level <= '0;
			cfg_q.water_alpha <= 8'd128;
			cfg_q.water_rgb   <= 24'd255;
		end else if (wr_en) begin
			case (wr_index)
				REG_HUE_START:   cfg_q.hue_start   <= wr_data[HUE_W-1:0];
				REG_HUE_RANGE:   cfg_q.hue_range   <= wr_data[HUE_W-1:0];
				REG_SATURATION:  cfg_q.saturation  <= wr_data[SAT_W-1:0];
				REG_BRIGHTNESS:  cfg_q.brightness  <= wr_data[SAT_W-1:0];
				REG_MODE_FLAGS:  cfg_q.mode_flags  <= wr_data[1:0];
				REG_WATER_LEVEL: cfg_q.water_level <= $signed(wr_data[23:0]);
				REG_WATER_ALPHA: cfg_q.water_alpha <= wr_data[7:0];
				REG_WATER_RGB:   cfg_q.water_rgb   <= wr_data[23:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic       hue_valid;
	logic [2:0] hue_sector;
	logic [9:0] hue_frac;
	side_t      hue_side;

	ehc_hue_map u_hue_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.item      (in_item),
		.cfg       (cfg_q),
		.out_valid (hue_valid),
		.sector    (hue_sector),
		.frac      (hue_frac),
		.side      (hue_side)
	);

	logic            rgb_valid;
	logic [2:0][7:0] rgb_ch;
	side_t           rgb_side;

	ehc_hsv_rgb u_hsv_rgb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.sector    (hue_sector),
		.frac      (hue_frac),
		.side_in   (hue_side),
		.cfg       (cfg_q),
		.out_valid (rgb_valid),
		.ch        (rgb_ch),
		.side      (rgb_side)
	);

	ehc_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rgb_valid),
		.ch        (rgb_ch),
		.side_in   (rgb_side),
		.cfg       (cfg_q),
		.out_valid (done),
		.result    (result)
	);

	// Every accepted pixel yields exactly one strobe after the fixed latency.
	`ASSERT_DELAYED(a_lat_fwd, start && !busy, PIPE_LAT, done)
	`ASSERT_IMPLIES(a_lat_back, done, $past(start, PIPE_LAT))

endmodule

@@ tb/sv/elevation_hsv_colorize_checker.sv @@
// Checker of the elevation colorizer: watches the pixel, color and config ports.
// Keeps its own copy of the registers, predicts each color and compares in order.
// Depends on ehc_pkg.
`timescale 1ns / 100ps
module elevation_hsv_colorize_checker import ehc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  item_t            in_item,
	input  logic             done,
	input  result_t          result,
	input  logic             wr_en,
	input  reg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output int               errors,
	output int               colors_pending
);

	cfg_t    regs;
	result_t colors_due[$];

	function automatic cfg_t reset_regs();
		cfg_t c;
		c.hue_start   = '0;
		c.hue_range   = 13'd5760;
		c.saturation  = 17'd65536;
		c.brightness  = 17'd65536;
		c.mode_flags  = 2'd3;
		c.water_level = '0;
		c.water_alpha = 8'd128;
		c.water_rgb   = 24'd255;
		return c;
	endfunction

	function automatic logic [7:0] clamp_byte(longint num, longint den);
		longint q;
		if (num <= 0)
			return 8'd0;
		q = (num * 255) / den;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [7:0] mix_water(int c, int w, int a);
		if (w >= c)
			return 8'(c + ((w - c) * a) / 255);
		return 8'(c - ((c - w) * a) / 255);
	endfunction

	function automatic result_t colorize(item_t it, cfg_t c);
		longint elev, lo, hi, span, pos, hue, f, s, v, den, vq, p1, p2, p3;
		longint r, g, b;
		int ch[3];
		result_t res;
		elev = longint'(it.elevation);
		lo   = longint'(it.min_elevation);
		hi   = longint'(it.max_elevation);
		if (it.keep_color) begin
			ch[0] = int'(it.in_red);
			ch[1] = int'(it.in_green);
			ch[2] = int'(it.in_blue);
		end else begin
			span = hi - lo;
			pos  = elev - lo;
			if (span < 1)
				span = 1;
			if (pos < 0)
				pos = 0;
			if (pos > span)
				pos = span;
			hue = (longint'(c.hue_range) * pos) / span + longint'(c.hue_start);
			hue = hue % HUE_FULL;
			f   = hue % HUE_SECTOR;
			s   = longint'(c.saturation);
			v   = longint'(c.brightness);
			// Everything is scaled by 2^32 times the sector width.
			den = 64'd65536 * 65536 * HUE_SECTOR;
			vq  = v * 65536 * HUE_SECTOR;
			p1  = v * (65536 - s) * HUE_SECTOR;
			p2  = v * (longint'(65536) * HUE_SECTOR - s * f);
			p3  = v * (longint'(65536) * HUE_SECTOR - s * (HUE_SECTOR - f));
			case (hue / HUE_SECTOR)
				0: begin r = vq; g = p3; b = p1; end
				1: begin r = p2; g = vq; b = p1; end
				2: begin r = p1; g = vq; b = p3; end
				3: begin r = p1; g = p2; b = vq; end
				4: begin r = p3; g = p1; b = vq; end
				default: begin r = vq; g = p1; b = p2; end
			endcase
			ch[0] = int'(clamp_byte(r, den));
			ch[1] = int'(clamp_byte(g, den));
			ch[2] = int'(clamp_byte(b, den));
		end
		if (c.mode_flags[0])
			for (int k = 0; k < 3; k++)
				ch[k] = (int'(it.light_intensity) * ch[k]) / 255;
		if (c.mode_flags[1] && elev <= longint'(c.water_level) && c.water_alpha != 0) begin
			ch[0] = int'(mix_water(ch[0], int'(c.water_rgb[23:16]), int'(c.water_alpha)));
			ch[1] = int'(mix_water(ch[1], int'(c.water_rgb[15:8]), int'(c.water_alpha)));
			ch[2] = int'(mix_water(ch[2], int'(c.water_rgb[7:0]), int'(c.water_alpha)));
		end
		res.out_red   = ch[0][7:0];
		res.out_green = ch[1][7:0];
		res.out_blue  = ch[2][7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs = reset_regs();
			colors_due.delete();
			errors = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HUE_START:   regs.hue_start   = wr_data[12:0];
					REG_HUE_RANGE:   regs.hue_range   = wr_data[12:0];
					REG_SATURATION:  regs.saturation  = wr_data[16:0];
					REG_BRIGHTNESS:  regs.brightness  = wr_data[16:0];
					REG_MODE_FLAGS:  regs.mode_flags  = wr_data[1:0];
					REG_WATER_LEVEL: regs.water_level = wr_data[23:0];
					REG_WATER_ALPHA: regs.water_alpha = wr_data[7:0];
					REG_WATER_RGB:   regs.water_rgb   = wr_data[23:0];
					default: ;
				endcase
			end
			if (start && !busy)
				colors_due.push_back(colorize(in_item, regs));
			if (done) begin
				if (colors_due.size() == 0) begin
					$error("color transaction with nothing expected: %h", result);
					errors++;
				end else begin
					want = colors_due.pop_front();
					if (result.out_red !== want.out_red) begin
						$error("out_red expected %0d actual %0d", want.out_red, result.out_red);
						errors++;
					end
					if (result.out_green !== want.out_green) begin
						$error("out_green expected %0d actual %0d", want.out_green,
							result.out_green);
						errors++;
					end
					if (result.out_blue !== want.out_blue) begin
						$error("out_blue expected %0d actual %0d", want.out_blue,
							result.out_blue);
						errors++;
					end
				end
			end
		end
		colors_pending = colors_due.size();
	end

endmodule

@@ tb/sv/elevation_hsv_colorize_unit_tb.sv @@
// Testbench top of the elevation colorizer: clock, reset, stimulus and verdict.
// Depends on ehc_pkg, the colorizer RTL and elevation_hsv_colorize_checker.
`timescale 1ns / 100ps
module elevation_hsv_colorize_unit_tb;
	import ehc_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	item_t            in_item = '0;
	logic             done;
	result_t          result;
	logic             wr_en = 1'b0;
	reg_idx_t         wr_index = REG_HUE_START;
	logic [CFG_W-1:0] wr_data = '0;
	int               errors;
	int               colors_pending;
	int               pixels_sent = 0;

	always #1 clk = ~clk;

	elevation_hsv_colorize_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	elevation_hsv_colorize_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .errors(errors), .colors_pending(colors_pending)
	);

	// One register write per call; the caller makes sure the pipeline is empty.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic load_regs(cfg_t c);
		write_reg(REG_HUE_START, CFG_W'(c.hue_start));
		write_reg(REG_HUE_RANGE, CFG_W'(c.hue_range));
		write_reg(REG_SATURATION, CFG_W'(c.saturation));
		write_reg(REG_BRIGHTNESS, CFG_W'(c.brightness));
		write_reg(REG_MODE_FLAGS, CFG_W'(c.mode_flags));
		write_reg(REG_WATER_LEVEL, c.water_level);
		write_reg(REG_WATER_ALPHA, CFG_W'(c.water_alpha));
		write_reg(REG_WATER_RGB, c.water_rgb);
	endtask

	// Drives one pixel transaction, with random idle cycles in front of it.
	// Start stays high from one pixel to the next when no idle cycle falls between.
	task automatic send_pixel(item_t it, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start   = 1'b1;
		in_item = it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pixels_sent++;
	endtask

	// Lets the pipeline empty out. A margin beyond the pipeline depth covers any
	// color still in flight after the last one was checked.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (colors_pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic item_t make_pixel(int e, int lo, int hi, int inten, bit keep);
		item_t it;
		it.elevation       = e[23:0];
		it.min_elevation   = lo[23:0];
		it.max_elevation   = hi[23:0];
		it.light_intensity = inten[7:0];
		it.keep_color      = keep;
		it.in_red          = 8'($urandom);
		it.in_green        = 8'($urandom);
		it.in_blue         = 8'($urandom);
		return it;
	endfunction

	// Mostly a sensible map range with the elevation around it; sometimes
	// everything fully random, which covers empty and inverted spans too.
	function automatic item_t random_pixel();
		int lo, span, e, kind;
		kind = $urandom_range(9);
		if (kind < 2)
			return make_pixel($urandom, $urandom, $urandom, $urandom,
				1'($urandom_range(1)));
		lo   = $signed($urandom_range(32'hFFFFFF)) - 32'sh800000;
		span = (kind < 6) ? $urandom_range(4000) : $urandom_range(32'hFFFFFF);
		e    = lo + $signed($urandom_range(span + span / 2)) - span / 4;
		return make_pixel(e, lo, lo + span, $urandom,
			($urandom_range(4) == 0));
	endfunction

	function automatic cfg_t random_regs();
		cfg_t c;
		c.hue_start   = 13'($urandom);
		c.hue_range   = $urandom_range(1) ? 13'($urandom_range(5760)) : 13'($urandom);
		c.saturation  = $urandom_range(1) ? 17'($urandom_range(65536)) : 17'($urandom);
		c.brightness  = $urandom_range(1) ? 17'($urandom_range(65536)) : 17'($urandom);
		c.mode_flags  = 2'($urandom);
		c.water_level = $urandom_range(1) ? 24'($signed($urandom_range(2000)) - 1000)
			: 24'($urandom);
		c.water_alpha = 8'($urandom);
		c.water_rgb   = 24'($urandom);
		return c;
	endfunction

	initial begin
		cfg_t c;
		int idle_pct;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pixels at the reset settings: map extremes, clipped
		// elevations, empty and inverted spans, and the kept color.
		send_pixel(make_pixel(-8388608, -8388608, 8388607, 255, 0), 0);
		send_pixel(make_pixel(8388607, -8388608, 8388607, 255, 0), 0);
		send_pixel(make_pixel(0, -8388608, 8388607, 0, 0), 0);
		send_pixel(make_pixel(-8388608, 0, 100, 255, 0), 0);
		send_pixel(make_pixel(8388607, 0, 100, 255, 0), 0);
		send_pixel(make_pixel(50, 100, 100, 200, 0), 0);
		send_pixel(make_pixel(150, 100, 100, 200, 0), 0);
		send_pixel(make_pixel(5, 100, -100, 128, 0), 0);
		for (int h = 0; h < 6; h++)
			send_pixel(make_pixel(h * 160 + 80, 0, 960, 255, 0), 0);
		send_pixel(make_pixel(1, 0, 0, 255, 1), 0);
		send_pixel('{elevation: 24'd10, min_elevation: 24'd0, max_elevation: 24'd20,
			light_intensity: 8'd255, keep_color: 1'b1, in_red: 8'hFF, in_green: 8'h00,
			in_blue: 8'hFF}, 0);
		send_pixel('{elevation: 24'hFFFFFF, min_elevation: 24'd0, max_elevation: 24'd20,
			light_intensity: 8'd77, keep_color: 1'b1, in_red: 8'h00, in_green: 8'hFF,
			in_blue: 8'h00}, 0);
		drain();

		// Extreme settings: hue past a full turn, saturation and value above one,
		// shading and water off, lowest water level.
		c = '{hue_start: 13'h1FFF, hue_range: 13'h1FFF, saturation: 17'h1FFFF,
			brightness: 17'h1FFFF, mode_flags: 2'd0, water_level: 24'h800000,
			water_alpha: 8'd0, water_rgb: 24'h000000};
		load_regs(c);
		for (int i = 0; i < 12; i++)
			send_pixel(random_pixel(), 0);
		drain();

		// Other extreme: zero saturation and value, both modes, full water.
		c = '{hue_start: 13'd5759, hue_range: 13'd0, saturation: 17'd0,
			brightness: 17'd0, mode_flags: 2'd3, water_level: 24'h7FFFFF,
			water_alpha: 8'd255, water_rgb: 24'hFFFFFF};
		load_regs(c);
		for (int i = 0; i < 6; i++)
			send_pixel(random_pixel(), 0);
		drain();

		// Random phases, each with its own settings and sender idling.
		for (int ph = 0; ph < 8; ph++) begin
			load_regs(random_regs());
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 54;
				2: idle_pct = 0;
				default: idle_pct = 8;
			endcase
			for (int i = 0; i < 235; i++)
				send_pixel(random_pixel(), idle_pct);
			drain();
		end

		$display("Sent %0d pixels over directed, extreme and eight random register sets,",
			pixels_sent);
		$display("with back-to-back and idle-heavy phases and a full drain between them.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
